// ===== rtl/core/spring_force_separation_ramp_macros.svh =====
// Assertion macros for the spring force block checker
`ifndef SPRING_FORCE_SEPARATION_RAMP_MACROS_SVH
`define SPRING_FORCE_SEPARATION_RAMP_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define SFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/core/sfr_pkg.sv =====
// Package: widths, types and state codes of the spring force block
`default_nettype none
package sfr_pkg;
	localparam int POS_W = 24;
	localparam int SEP_W = 25;
	localparam int OUT_W = 32;
	localparam int K_W = 24;
	localparam int STEP_W = 24;
	localparam int CFG_W = 25;
	localparam int IDX_W = 2;
	localparam int SUMSQ_W = 2 * POS_W + 2;
	localparam int DEF_FRAC_BITS = 16;
	localparam int DEF_PERIOD_WIDTH = 16;

	localparam logic [IDX_W-1:0] REG_SPRING_K = 2'd0;
	localparam logic [IDX_W-1:0] REG_SEP_STEP = 2'd1;
	localparam logic [IDX_W-1:0] REG_PERIOD = 2'd2;
	localparam logic [IDX_W-1:0] REG_START = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQRT, ST_MAG, ST_DIV, ST_OUT
	} state_t;

	// input transfer: positions of the two particles
	typedef struct packed {
		logic [POS_W-1:0] first_x;
		logic [POS_W-1:0] first_y;
		logic [POS_W-1:0] first_z;
		logic [POS_W-1:0] second_x;
		logic [POS_W-1:0] second_y;
		logic [POS_W-1:0] second_z;
	} pair_t;

	// output transfer: forces, separation, magnitude, target, zero flag
	typedef struct packed {
		logic [OUT_W-1:0] force_x;
		logic [OUT_W-1:0] force_y;
		logic [OUT_W-1:0] force_z;
		logic [SEP_W-1:0] separation;
		logic [OUT_W-1:0] force_magnitude;
		logic [OUT_W-1:0] used_target;
		logic zero_separation;
	} spring_res_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic sqrt_start;
		logic sqrt_step;
		logic mag;
		logic div_start;
		logic div_step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sqrt_last;
		logic div_last;
		logic div_lane_last;
	} stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/sfr_if.sv =====
// Valid/ready channel interface with generic payload
`default_nettype none
interface sfr_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sfr_ctrl.sv =====
// Controller state machine sequencing root, magnitude and division
`default_nettype none
module sfr_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire sfr_pkg::stat_t stat,
	output sfr_pkg::cmd_t cmd
);
	sfr_pkg::state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sfr_pkg::ST_IDLE: if (in_valid) state_d = sfr_pkg::ST_SQRT;
			sfr_pkg::ST_SQRT: if (stat.sqrt_last) state_d = sfr_pkg::ST_MAG;
			sfr_pkg::ST_MAG: state_d = sfr_pkg::ST_DIV;
			sfr_pkg::ST_DIV: if (stat.div_last) state_d = sfr_pkg::ST_OUT;
			sfr_pkg::ST_OUT: if (out_ready) state_d = sfr_pkg::ST_IDLE;
			default: state_d = sfr_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			sfr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				cmd.sqrt_start = in_valid;
			end
			sfr_pkg::ST_SQRT: cmd.sqrt_step = 1'b1;
			sfr_pkg::ST_MAG: begin
				cmd.mag = 1'b1;
				cmd.div_start = 1'b1;
			end
			sfr_pkg::ST_DIV: cmd.div_step = 1'b1;
			sfr_pkg::ST_OUT: begin
				out_valid = 1'b1;
				cmd.finish = out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sfr_pkg::ST_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

// ===== rtl/core/sfr_datapath.sv =====
// Datapath: squared distance, bit-serial root, gain product, serial divide, ramp
`default_nettype none
module sfr_datapath #(
	parameter int FRAC_BITS = sfr_pkg::DEF_FRAC_BITS,
	parameter int PERIOD_WIDTH = sfr_pkg::DEF_PERIOD_WIDTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire sfr_pkg::cmd_t cmd,
	output sfr_pkg::stat_t stat,
	input wire logic [sfr_pkg::POS_W-1:0] pos [6],
	input wire logic cfg_we,
	input wire logic [sfr_pkg::IDX_W-1:0] cfg_idx,
	input wire logic [sfr_pkg::CFG_W-1:0] cfg_data,
	input wire logic [PERIOD_WIDTH-1:0] period_in,
	output logic signed [sfr_pkg::OUT_W-1:0] force_o [3],
	output logic [sfr_pkg::SEP_W-1:0] sep_o,
	output logic signed [sfr_pkg::OUT_W-1:0] mag_o,
	output logic signed [sfr_pkg::OUT_W-1:0] used_o,
	output logic zero_o
);
	localparam int PW = sfr_pkg::POS_W;
	localparam int SW = sfr_pkg::SUMSQ_W;
	localparam int RW = SW / 2;          // root width, 25
	localparam int DIVW = sfr_pkg::OUT_W + PW;  // dividend width, 56
	localparam int DCW = $clog2(DIVW + 1);
	localparam int RCW = $clog2(RW);

	// configuration
	logic [sfr_pkg::K_W-1:0] k_q;
	logic [sfr_pkg::STEP_W-1:0] step_q;
	logic signed [sfr_pkg::OUT_W-1:0] target_q;
	logic [PERIOD_WIDTH-1:0] count_q;

	// difference vector
	logic [PW-1:0] ad_q [3];
	logic neg_q [3];
	logic [SW-1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [SW-1:0] rad_q;
	logic [RCW-1:0] rcnt_q;

	logic signed [sfr_pkg::OUT_W-1:0] mag_q;
	logic [sfr_pkg::OUT_W-1:0] amag_q;
	logic mneg_q;

	// divider
	logic [1:0] lane_q;
	logic [DCW-1:0] dcnt_q;
	logic [DIVW-1:0] num_q;
	logic [RW:0] drem_q;
	logic signed [sfr_pkg::OUT_W-1:0] frc_q [3];

	// difference magnitudes on load
	logic [PW:0] dsub [3];
	always_comb begin
		for (int i = 0; i < 3; i++) dsub[i] = {1'b0, pos[i]} - {1'b0, pos[i+3]};
	end

	// square root step on the two top bits of the radicand
	logic [SW-1:0] rem_sh;
	logic [SW-1:0] trial;
	always_comb begin
		rem_sh = {rem_q[SW-3:0], rad_q[SW-1:SW-2]};
		trial = {{(SW-RW-2){1'b0}}, root_q, 2'b01};
	end

	// gain product
	logic signed [sfr_pkg::OUT_W:0] diff;
	logic [sfr_pkg::OUT_W:0] adiff;
	logic [sfr_pkg::OUT_W+sfr_pkg::K_W:0] prod;
	logic [sfr_pkg::OUT_W+sfr_pkg::K_W:0] pm;
	always_comb begin
		diff = {target_q[sfr_pkg::OUT_W-1], target_q} - $signed({8'd0, root_q});
		adiff = diff[sfr_pkg::OUT_W] ? (~diff + 1'b1) : diff;
		prod = {{sfr_pkg::K_W{1'b0}}, adiff} * {{(sfr_pkg::OUT_W+1){1'b0}}, k_q};
		pm = prod >> FRAC_BITS;
	end

	// restoring divide step
	logic [RW+1:0] dtry;
	logic [RW:0] dshift;
	logic qbit;
	logic [DIVW-1:0] qnext;
	always_comb begin
		dshift = {drem_q[RW-1:0], num_q[DIVW-1]};
		dtry = {1'b0, dshift} - {2'b0, root_q};
		qbit = !dtry[RW+1];
		qnext = {num_q[DIVW-2:0], qbit};
	end

	// ramp update
	logic [PERIOD_WIDTH-1:0] next_cnt, per_eff;
	logic signed [sfr_pkg::OUT_W:0] tsum;
	always_comb begin
		next_cnt = count_q + 1'b1;
		per_eff = (period_in == '0) ? {{(PERIOD_WIDTH-1){1'b0}}, 1'b1} : period_in;
		tsum = {target_q[sfr_pkg::OUT_W-1], target_q}
			+ {{(sfr_pkg::OUT_W+1-sfr_pkg::STEP_W){step_q[sfr_pkg::STEP_W-1]}}, step_q};
	end

	// current lane operand and divider start value
	logic [DIVW-1:0] lane_prod;
	always_comb begin
		lane_prod = amag_q * ad_q[lane_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			step_q <= '0;
			target_q <= '0;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					sfr_pkg::REG_SPRING_K: k_q <= cfg_data[sfr_pkg::K_W-1:0];
					sfr_pkg::REG_SEP_STEP: step_q <= cfg_data[sfr_pkg::STEP_W-1:0];
					sfr_pkg::REG_START: target_q <= {7'd0, cfg_data};
					default: ;
				endcase
			end
			if (cmd.finish) begin
				if (next_cnt >= per_eff || next_cnt == '0) begin
					count_q <= '0;
					if (tsum > $signed(33'sh0_7FFF_FFFF)) target_q <= 32'sh7FFF_FFFF;
					else if (tsum < -$signed(33'sh0_8000_0000)) target_q <= 32'sh8000_0000;
					else target_q <= tsum[sfr_pkg::OUT_W-1:0];
				end else count_q <= next_cnt;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				neg_q[i] <= dsub[i][PW];
				ad_q[i] <= dsub[i][PW] ? PW'(-dsub[i]) : dsub[i][PW-1:0];
			end
		end
		if (cmd.sqrt_start) begin
			rad_q <= '0;
			rem_q <= '0;
			root_q <= '0;
			rcnt_q <= '0;
		end
		// first sqrt cycle forms the sum of squares
		if (cmd.sqrt_step) begin
			if (rcnt_q == '0 && rad_q == '0 && root_q == '0 && rem_q == '0
				&& !stat.sqrt_last) begin
				rad_q <= SW'(ad_q[0] * ad_q[0]) + SW'(ad_q[1] * ad_q[1])
					+ SW'(ad_q[2] * ad_q[2]);
				rcnt_q <= RCW'(1);
			end else begin
				rad_q <= rad_q << 2;
				if (rem_sh >= trial) begin
					rem_q <= rem_sh - trial;
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					root_q <= {root_q[RW-2:0], 1'b0};
				end
				rcnt_q <= rcnt_q + 1'b1;
			end
		end
		if (cmd.mag) begin
			if (prod[sfr_pkg::OUT_W+sfr_pkg::K_W:sfr_pkg::OUT_W-1] != '0 && !(
				diff[sfr_pkg::OUT_W] && pm == {1'b1, {(sfr_pkg::OUT_W-1){1'b0}}})) begin
				if (pm[sfr_pkg::OUT_W+sfr_pkg::K_W:sfr_pkg::OUT_W-1] != '0) begin
					mag_q <= diff[sfr_pkg::OUT_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
					amag_q <= diff[sfr_pkg::OUT_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				end else begin
					mag_q <= diff[sfr_pkg::OUT_W] ? -$signed(pm[sfr_pkg::OUT_W-1:0])
						: $signed(pm[sfr_pkg::OUT_W-1:0]);
					amag_q <= pm[sfr_pkg::OUT_W-1:0];
				end
			end else begin
				mag_q <= diff[sfr_pkg::OUT_W] ? -$signed(pm[sfr_pkg::OUT_W-1:0])
					: $signed(pm[sfr_pkg::OUT_W-1:0]);
				amag_q <= pm[sfr_pkg::OUT_W-1:0];
			end
			mneg_q <= diff[sfr_pkg::OUT_W] && pm != '0;
			lane_q <= '0;
		end
		if (cmd.div_start) dcnt_q <= '0;
		// one lane: operand load, then one quotient bit a cycle
		if (cmd.div_step) begin
			if (dcnt_q == '0) begin
				num_q <= lane_prod;
				drem_q <= '0;
				dcnt_q <= DCW'(1);
			end else begin
				drem_q <= qbit ? dtry[RW:0] : dshift;
				num_q <= qnext;
				if (stat.div_lane_last) begin
					// quotient finishes with this bit
					dcnt_q <= '0;
					if (root_q == '0) frc_q[lane_q] <= '0;
					else if (qnext > DIVW'(32'h7FFF_FFFF) && mneg_q == neg_q[lane_q])
						frc_q[lane_q] <= 32'sh7FFF_FFFF;
					else if (mneg_q != neg_q[lane_q])
						frc_q[lane_q] <= -$signed(qnext[sfr_pkg::OUT_W-1:0]);
					else frc_q[lane_q] <= $signed(qnext[sfr_pkg::OUT_W-1:0]);
					if (lane_q != 2'd2) lane_q <= lane_q + 1'b1;
				end else dcnt_q <= dcnt_q + 1'b1;
			end
		end
	end

	assign stat.sqrt_last = (rcnt_q == RCW'(RW));
	assign stat.div_lane_last = (dcnt_q == DCW'(DIVW));
	assign stat.div_last = stat.div_lane_last && lane_q == 2'd2;

	always_comb begin
		for (int i = 0; i < 3; i++) force_o[i] = frc_q[i];
	end
	assign sep_o = root_q;
	assign mag_o = mag_q;
	assign used_o = target_q;
	assign zero_o = (root_q == '0);
endmodule
`default_nettype wire

// ===== rtl/core/spring_force_separation_ramp.sv =====
// Top level of the harmonic spring force block with ramped target
//
// Usage: one input transfer carries the six particle coordinates (Q8.16).
// One output transfer returns force components, separation, force
// magnitude, the target in force and a zero-separation flag.
// Configuration is a plain write port: cfg_we, cfg_index, cfg_data;
// writing start_separation reloads the target at once.
// Processing: bit-serial square root (sum of squares, then 25 root bits),
// one gain-product step, then restoring division for each of the three
// components (operand load plus 56 quotient bits each), after which the
// result is offered. One item is in flight: no new input is taken until
// the result has been transferred. The result holds in the output
// register until taken; a stalled receiver delays the next input. The
// ramp counter advances on the output transfer. Reset clears
// configuration to defaults, target to zero and the counter to zero;
// no clearing pass is needed.
`default_nettype none
module spring_force_separation_ramp #(
	parameter int POSITION_FRAC_BITS = sfr_pkg::DEF_FRAC_BITS,
	parameter int PERIOD_WIDTH = sfr_pkg::DEF_PERIOD_WIDTH
) (
	input wire logic clk,
	input wire logic arst_n,
	sfr_if.sink in_ch,
	sfr_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [sfr_pkg::IDX_W-1:0] cfg_index,
	input wire logic [sfr_pkg::CFG_W-1:0] cfg_data
);
	sfr_pkg::cmd_t cmd;
	sfr_pkg::stat_t stat;
	logic [sfr_pkg::POS_W-1:0] pos [6];
	logic signed [sfr_pkg::OUT_W-1:0] frc [3];
	logic [PERIOD_WIDTH-1:0] period_q;

	// ramp period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) period_q <= {{(PERIOD_WIDTH-1){1'b0}}, 1'b1};
		else if (cfg_we && cfg_index == sfr_pkg::REG_PERIOD)
			period_q <= PERIOD_WIDTH'(cfg_data[15:0]);
	end

	assign pos[0] = in_ch.data.first_x;
	assign pos[1] = in_ch.data.first_y;
	assign pos[2] = in_ch.data.first_z;
	assign pos[3] = in_ch.data.second_x;
	assign pos[4] = in_ch.data.second_y;
	assign pos[5] = in_ch.data.second_z;

	sfr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	sfr_datapath #(.FRAC_BITS(POSITION_FRAC_BITS), .PERIOD_WIDTH(PERIOD_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .pos(pos),
		.cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.period_in(period_q),
		.force_o(frc), .sep_o(out_ch.data.separation),
		.mag_o(out_ch.data.force_magnitude), .used_o(out_ch.data.used_target),
		.zero_o(out_ch.data.zero_separation)
	);

	assign out_ch.data.force_x = frc[0];
	assign out_ch.data.force_y = frc[1];
	assign out_ch.data.force_z = frc[2];
endmodule
`default_nettype wire

// ===== rtl/core/sfr_checker.sv =====
// Port-level checker for the spring force block, bound to the top level
`default_nettype none
`include "spring_force_separation_ramp_macros.svh"
module sfr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic zero_sep,
	input wire logic signed [31:0] force_x
);
	// one item at a time: no input taken while a result waits
	`SFR_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	// result stays offered until transferred
	`SFR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// no result the cycle after an input transfer
	`SFR_ASSERT_NEXT(a_latency, clk, arst_n, in_valid && in_ready, !out_valid)
	// zero separation means zero x force component
	`SFR_ASSERT_IMP(a_zero_force, clk, arst_n, out_valid && zero_sep, force_x == 32'sd0)
endmodule
bind spring_force_separation_ramp sfr_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.zero_sep(out_ch.data.zero_separation), .force_x(out_ch.data.force_x)
);
`default_nettype wire

// ===== verif/tb_pkg.sv =====
// Payload types for the spring force testbench channels
`timescale 1ns / 1ps
package tb_pkg;
	typedef sfr_pkg::pair_t pair_t;
	typedef sfr_pkg::spring_res_t spring_res_t;
endpackage

// ===== verif/tb_top.sv =====
// Testbench for the spring force block: directed, ramp and random tests
`timescale 1ns / 1ps
module tb_top;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [sfr_pkg::IDX_W-1:0] cfg_index;
	logic [sfr_pkg::CFG_W-1:0] cfg_data;

	sfr_if #(.payload_t(tb_pkg::pair_t)) in_ch ();
	sfr_if #(.payload_t(tb_pkg::spring_res_t)) out_ch ();

	spring_force_separation_ramp u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the block's configuration and ramp state
	logic [sfr_pkg::K_W-1:0] gain_k;
	logic [sfr_pkg::STEP_W-1:0] ramp_step;
	logic [15:0] ramp_len;
	longint target_sep;
	logic [15:0] ramp_cnt;

	tb_pkg::spring_res_t force_queue[$];
	int errors;
	longint cycles;
	bit steady;  // no idling on either side while set

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL spring_force_separation_ramp");
			$finish;
		end
	end

	function automatic longint clamp32(longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	// expected result for one pair; advances the ramp state
	function automatic tb_pkg::spring_res_t spring_force(tb_pkg::pair_t p);
		tb_pkg::spring_res_t r;
		longint d[3];
		longint unsigned sumsq;
		longint unsigned sep;
		longint unsigned ad;
		longint unsigned q;
		longint diff;
		longint mag;
		longint f[3];
		longint unsigned prod;
		logic [15:0] nxt;
		logic [15:0] per;
		d[0] = longint'(p.first_x) - longint'(p.second_x);
		d[1] = longint'(p.first_y) - longint'(p.second_y);
		d[2] = longint'(p.first_z) - longint'(p.second_z);
		sumsq = 0;
		for (int i = 0; i < 3; i++) begin
			ad = d[i] < 0 ? -d[i] : d[i];
			sumsq += ad * ad;
		end
		sep = int_sqrt(sumsq);
		diff = target_sep - longint'(sep);
		prod = longint'(gain_k) * (diff < 0 ? -diff : diff);
		mag = longint'(prod >> sfr_pkg::DEF_FRAC_BITS);
		mag = clamp32(diff < 0 ? -mag : mag);
		for (int i = 0; i < 3; i++) begin
			if (sep == 0) begin
				f[i] = 0;
			end else begin
				q = ((mag < 0 ? -mag : mag) * (d[i] < 0 ? -d[i] : d[i])) / sep;
				f[i] = clamp32(((mag < 0) != (d[i] < 0)) ? -longint'(q) : longint'(q));
			end
		end
		r.force_x = f[0][31:0];
		r.force_y = f[1][31:0];
		r.force_z = f[2][31:0];
		r.separation = sep[sfr_pkg::SEP_W-1:0];
		r.force_magnitude = mag[31:0];
		r.used_target = target_sep[31:0];
		r.zero_separation = (sep == 0);
		// ramp: zero period acts as one
		per = (ramp_len == 0) ? 16'd1 : ramp_len;
		nxt = ramp_cnt + 16'd1;
		if (nxt >= per || nxt == 0) begin
			ramp_cnt = 0;
			target_sep = clamp32(target_sep + longint'(signed'(ramp_step)));
		end else begin
			ramp_cnt = nxt;
		end
		return r;
	endfunction

	task automatic write_reg(logic [sfr_pkg::IDX_W-1:0] idx, logic [sfr_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			sfr_pkg::REG_SPRING_K: gain_k = val[sfr_pkg::K_W-1:0];
			sfr_pkg::REG_SEP_STEP: ramp_step = val[sfr_pkg::STEP_W-1:0];
			sfr_pkg::REG_PERIOD: ramp_len = val[15:0];
			sfr_pkg::REG_START: target_sep = longint'(val);
			default: ;
		endcase
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_all(logic [sfr_pkg::K_W-1:0] k, logic [sfr_pkg::STEP_W-1:0] st,
			logic [15:0] per, logic [sfr_pkg::SEP_W-1:0] start);
		write_reg(sfr_pkg::REG_SPRING_K, sfr_pkg::CFG_W'(k));
		write_reg(sfr_pkg::REG_SEP_STEP, sfr_pkg::CFG_W'(st));
		write_reg(sfr_pkg::REG_PERIOD, sfr_pkg::CFG_W'(per));
		write_reg(sfr_pkg::REG_START, start);
		end_writes();
	endtask

	// idle: all results back, then a short margin
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (force_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one input transfer, expectation formed at acceptance
	task automatic send_pair(tb_pkg::pair_t p);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= p;
		do @(posedge clk); while (!in_ch.ready);
		force_queue.push_back(spring_force(p));
	endtask

	function automatic tb_pkg::pair_t mk_pair(logic [23:0] ax, logic [23:0] ay,
			logic [23:0] az, logic [23:0] bx, logic [23:0] by, logic [23:0] bz);
		tb_pkg::pair_t p;
		p.first_x = ax; p.first_y = ay; p.first_z = az;
		p.second_x = bx; p.second_y = by; p.second_z = bz;
		return p;
	endfunction

	function automatic logic [23:0] near(logic [23:0] v, int span);
		int o;
		o = int'($urandom_range(0, 2 * span)) - span;
		return 24'(int'(v) + o);
	endfunction

	function automatic tb_pkg::pair_t rand_pair();
		tb_pkg::pair_t p;
		p = tb_pkg::pair_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
		case ($urandom_range(0, 9))
			0: begin
				p.second_x = p.first_x; p.second_y = p.first_y; p.second_z = p.first_z;
			end
			1, 2, 3: begin
				p.second_x = near(p.first_x, 4096);
				p.second_y = near(p.first_y, 4096);
				p.second_z = near(p.first_z, 4096);
			end
			4: begin
				p.second_x = near(p.first_x, 2);
				p.second_y = p.first_y;
				p.second_z = p.first_z;
			end
			default: ;
		endcase
		return p;
	endfunction

	// result checker
	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t mismatch %s: expected %h actual %h", $realtime, name, exp_v, act_v);
			errors++;
		end
	endtask

	initial begin
		tb_pkg::spring_res_t got;
		tb_pkg::spring_res_t exp_r;
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			got = out_ch.data;
			if (force_queue.size() == 0) begin
				$display("%0t unexpected result: expected none actual %h", $realtime, got);
				errors++;
			end else begin
				exp_r = force_queue.pop_front();
				check_field("force_x", exp_r.force_x, got.force_x);
				check_field("force_y", exp_r.force_y, got.force_y);
				check_field("force_z", exp_r.force_z, got.force_z);
				check_field("separation", 32'(exp_r.separation), 32'(got.separation));
				check_field("force_magnitude", exp_r.force_magnitude, got.force_magnitude);
				check_field("used_target", exp_r.used_target, got.used_target);
				check_field("zero_separation", 32'(exp_r.zero_separation),
					32'(got.zero_separation));
			end
		end
	end

	// extremes of positions, zero separation, sign combinations
	task automatic test_directed();
		set_all(24'h010000, 24'h000000, 16'd1, 25'h0020000);
		send_pair(mk_pair('0, '0, '0, '0, '0, '0));
		send_pair(mk_pair('1, '1, '1, '1, '1, '1));
		send_pair(mk_pair('1, '1, '1, '0, '0, '0));
		send_pair(mk_pair('0, '0, '0, '1, '1, '1));
		send_pair(mk_pair(24'h010000, '0, '0, '0, '0, '0));
		send_pair(mk_pair('0, 24'h000001, '0, '0, '0, '0));
		send_pair(mk_pair('0, '0, '0, '0, '0, 24'h000001));
		send_pair(mk_pair(24'h800000, 24'h123456, 24'h7fffff, 24'h7fffff, 24'h654321,
			24'h800000));
		drain();
		// saturated magnitude and components
		set_all('1, 24'h000000, 16'd1, '1);
		send_pair(mk_pair('0, '0, '0, '0, '0, '0));
		send_pair(mk_pair(24'h000001, '0, '0, '0, '0, '0));
		send_pair(mk_pair('0, 24'h000003, 24'h000004, '0, '0, '0));
		send_pair(mk_pair('1, '1, '1, '0, '0, '0));
		drain();
		set_all('1, 24'h000000, 16'd1, 25'h0000000);
		send_pair(mk_pair('1, '0, '1, '0, '1, '0));
		send_pair(mk_pair(24'h000005, '0, '0, '0, '0, '0));
		drain();
	endtask

	// ramp: zero period, saturation both ways, period lowered mid-ramp
	task automatic test_ramp();
		set_all(24'h008000, 24'h7fffff, 16'd0, '1);
		repeat (5) send_pair(rand_pair());
		repeat (300) send_pair(mk_pair('0, '0, '0, 24'h000010, '0, '0));
		drain();
		set_all(24'h020000, 24'h800000, 16'd1, 25'h0000000);
		repeat (300) send_pair(rand_pair());
		drain();
		set_all(24'h010000, 24'h000100, 16'd100, 25'h0100000);
		repeat (7) send_pair(rand_pair());
		drain();
		write_reg(sfr_pkg::REG_PERIOD, sfr_pkg::CFG_W'(16'd3));
		end_writes();
		repeat (10) send_pair(rand_pair());
		drain();
		set_all(24'h000001, 24'h000001, 16'hffff, 25'h0000001);
		repeat (20) send_pair(rand_pair());
		drain();
	endtask

	// random configurations with random pairs
	task automatic test_random();
		logic [sfr_pkg::K_W-1:0] k;
		logic [sfr_pkg::STEP_W-1:0] st;
		logic [15:0] per;
		for (int ph = 0; ph < 16; ph++) begin
			k = sfr_pkg::K_W'($urandom);
			st = sfr_pkg::STEP_W'($urandom);
			per = 16'($urandom_range(0, 8));
			if (ph % 4 == 1) st = {{10{st[23]}}, st[13:0]};
			if (ph % 5 == 2) per = 16'($urandom);
			set_all(k, st, per, sfr_pkg::CFG_W'($urandom));
			steady = (ph % 6 == 3);
			repeat (90) send_pair(rand_pair());
			steady = 1'b0;
			drain();
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		gain_k = '0;
		ramp_step = '0;
		ramp_len = 16'd1;
		target_sep = 0;
		ramp_cnt = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_ramp();
		test_random();
		drain();
		repeat (300) @(posedge clk);
		if (errors == 0 && force_queue.size() == 0) begin
			$display("PASS spring_force_separation_ramp");
		end else begin
			$display("FAIL spring_force_separation_ramp");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/sfr_pkg.sv
rtl/core/sfr_if.sv
rtl/core/sfr_ctrl.sv
rtl/core/sfr_datapath.sv
rtl/core/spring_force_separation_ramp.sv
rtl/core/sfr_checker.sv
verif/tb_pkg.sv
verif/tb_top.sv
